// ===== design/e2c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and constants for the epoch-to-calendar converter
// Holds the divider command/status types, the time constants and the month
// length table used by the serial divider and the calendar stepper.
// ----------------------------------------------------------------------------
package e2c_pkg;

	// divider geometry
	localparam int DVD_W  = 32;
	localparam int DIVR_W = 17;
	localparam int STEP_W = 6;

	localparam logic [DIVR_W-1:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [DIVR_W-1:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [DIVR_W-1:0] SECS_PER_MIN  = 17'd60;
	localparam logic [DIVR_W-1:0] DAYS_PER_WEEK = 17'd7;

	localparam logic [STEP_W-1:0] STEPS_DAY  = 6'd32;
	localparam logic [STEP_W-1:0] STEPS_HOUR = 6'd17;
	localparam logic [STEP_W-1:0] STEPS_MIN  = 6'd12;
	localparam logic [STEP_W-1:0] STEPS_WDAY = 6'd17;

	// 2^31 = BIAS_DAYS * 86400 + BIAS_SECS
	localparam logic [16:0] BIAS_DAYS    = 17'd24855;
	localparam logic [16:0] BIAS_SECS    = 17'd11648;
	localparam logic [16:0] BIAS_SECS_WR = 17'd74752;
	// multiple of seven plus four, since the epoch fell on a Thursday
	localparam logic [16:0] WDAY_BIAS    = 17'd28004;

	localparam logic [10:0] EPOCH_YEAR   = 11'd1970;
	localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
	localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
	localparam logic [8:0]  EPOCH_MOD400 = 9'd370;

	localparam logic [3:0]  MONTH_JAN = 4'd0;
	localparam logic [3:0]  MONTH_FEB = 4'd1;
	localparam logic [3:0]  MONTH_DEC = 4'd11;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// days in a month, month 0 is January
	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
		logic [4:0] len;
		case (mon)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
			MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== design/e2c_sdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_sdiv: bit-serial restoring divider
// Shifts the dividend in MSB first, one quotient bit per cycle, for a given
// number of steps. The dividend is left aligned so its top bits go first.
// ----------------------------------------------------------------------------
module e2c_sdiv import e2c_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_cmd_t          cmd,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [DIVR_W-1:0] divisor,
	output logic [DVD_W-1:0]  quot,
	output logic [DIVR_W-1:0] rem,
	output div_stat_t         stat
);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              ge;

	// trial subtract of one step
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	// advance one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.steps;
			dvd_q  <= dividend;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quot      = quo_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== design/e2c_cal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_cal: year and month stepper
// Walks a signed day count from 1970 one year per cycle, then one month per
// cycle, keeping year residues mod 4, 100 and 400 for the leap rule.
// ----------------------------------------------------------------------------
module e2c_cal import e2c_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] day_count,
	output logic               busy,
	output logic [10:0]        year,
	output logic [8:0]         yday,
	output logic [3:0]         month,
	output logic [4:0]         mday
);

	typedef enum logic [1:0] {C_IDLE, C_YEAR, C_MONTH} cal_state_t;

	cal_state_t         state_q;
	logic [10:0]        yr_q;
	logic [1:0]         m4_q;
	logic [6:0]         m100_q;
	logic [8:0]         m400_q;
	logic signed [15:0] day_q;
	logic [8:0]         doy_q;
	logic [3:0]         mon_q;
	logic               leap_q;

	logic        leap_cur, leap_prev;
	logic [1:0]  n4, p4;
	logic [6:0]  n100, p100;
	logic [8:0]  n400, p400;
	logic signed [15:0] len_cur, len_prev, mlen;

	// leap test of the current and the previous year
	always_comb begin
		n4   = m4_q + 2'd1;
		n100 = (m100_q == 7'd99)  ? 7'd0 : m100_q + 7'd1;
		n400 = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
		p4   = m4_q - 2'd1;
		p100 = (m100_q == 7'd0) ? 7'd99  : m100_q - 7'd1;
		p400 = (m400_q == 9'd0) ? 9'd399 : m400_q - 9'd1;
		leap_cur  = (m4_q == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
		leap_prev = (p4 == 2'd0) && ((p100 != 7'd0) || (p400 == 9'd0));
		len_cur   = leap_cur  ? 16'sd366 : 16'sd365;
		len_prev  = leap_prev ? 16'sd366 : 16'sd365;
		mlen      = $signed({11'd0, month_len(leap_q, mon_q)});
	end

	// step years, then months
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			yr_q    <= EPOCH_YEAR;
			m4_q    <= EPOCH_MOD4;
			m100_q  <= EPOCH_MOD100;
			m400_q  <= EPOCH_MOD400;
			day_q   <= '0;
			doy_q   <= '0;
			mon_q   <= MONTH_JAN;
			leap_q  <= 1'b0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						yr_q    <= EPOCH_YEAR;
						m4_q    <= EPOCH_MOD4;
						m100_q  <= EPOCH_MOD100;
						m400_q  <= EPOCH_MOD400;
						day_q   <= day_count;
						state_q <= C_YEAR;
					end
				end
				C_YEAR: begin
					if (day_q < 16'sd0) begin
						yr_q   <= yr_q - 11'd1;
						m4_q   <= p4;
						m100_q <= p100;
						m400_q <= p400;
						day_q  <= day_q + len_prev;
					end else if (day_q >= len_cur) begin
						yr_q   <= yr_q + 11'd1;
						m4_q   <= n4;
						m100_q <= n100;
						m400_q <= n400;
						day_q  <= day_q - len_cur;
					end else begin
						doy_q   <= day_q[8:0];
						leap_q  <= leap_cur;
						mon_q   <= MONTH_JAN;
						state_q <= C_MONTH;
					end
				end
				C_MONTH: begin
					if ((mon_q != MONTH_DEC) && (day_q >= mlen)) begin
						day_q <= day_q - mlen;
						mon_q <= mon_q + 4'd1;
					end else begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign busy  = state_q != C_IDLE;
	assign year  = yr_q;
	assign yday  = doy_q;
	assign month = mon_q;
	assign mday  = day_q[4:0] + 5'd1;

endmodule

// ===== design/epoch_seconds_to_calendar.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: signed epoch seconds to broken-down UTC time
// One serial divider splits days from seconds, then hours, minutes and the
// weekday; a stepper walks years and months from 1970 in parallel.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  input   | in_valid, in_stall  | epoch_seconds (32b signed)
//  output  | out_valid, out_stall| second_of_minute .. day_of_month
//
//  out_valid rises once the divider chain (day, hour, minute and weekday steps)
//  and the stepper (years, then months) are both through with an item; the next
//  item can be taken in the cycle after the result is loaded.
//  One item is in work at a time; in_stall is high while it is.
//  A finished item waits in the output register, and a new item is taken
//  while it waits. Reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar import e2c_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] epoch_seconds,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         second_of_minute,
	output logic [5:0]         minute_of_hour,
	output logic [4:0]         hour_of_day,
	output logic [2:0]         day_of_week,
	output logic [10:0]        calendar_year,
	output logic [8:0]         day_of_year,
	output logic [3:0]         month_index,
	output logic [4:0]         day_of_month
);

	typedef enum logic [2:0] {S_IDLE, S_DAY, S_HOUR, S_MIN, S_WDAY, S_CAL} top_state_t;

	top_state_t         state_q;
	logic signed [15:0] day_q;
	logic [4:0]         hour_q;
	logic [5:0]         min_q;
	logic [5:0]         sec_q;
	logic [2:0]         wday_q;
	logic               out_valid_q;
	logic [5:0]         o_sec_q, o_min_q;
	logic [4:0]         o_hour_q;
	logic [2:0]         o_wday_q;
	logic [10:0]        o_year_q;
	logic [8:0]         o_yday_q;
	logic [3:0]         o_mon_q;
	logic [4:0]         o_mday_q;

	div_cmd_t           div_cmd;
	div_stat_t          div_stat;
	logic [DVD_W-1:0]   div_dvd;
	logic [DIVR_W-1:0]  div_divr;
	logic [DVD_W-1:0]   div_quot;
	logic [DIVR_W-1:0]  div_rem;

	logic               cal_start;
	logic               cal_busy;
	logic [10:0]        cal_year;
	logic [8:0]         cal_yday;
	logic [3:0]         cal_mon;
	logic [4:0]         cal_mday;

	logic               in_take;
	logic               out_free;
	logic               out_load;
	logic               rem_ge;
	logic [16:0]        secs_c;
	logic [16:0]        day_wide;
	logic signed [15:0] day_c;
	logic [16:0]        wday_val;

	assign in_take  = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_CAL) && !cal_busy && out_free;

	// fold the bias of 2^31 back out of the day quotient and remainder
	always_comb begin
		rem_ge   = div_rem >= BIAS_SECS;
		secs_c   = rem_ge ? div_rem - BIAS_SECS : div_rem + BIAS_SECS_WR;
		day_wide = {1'b0, div_quot[15:0]} - BIAS_DAYS - {16'd0, !rem_ge};
		day_c    = $signed(day_wide[15:0]);
		wday_val = {day_q[15], day_q} + WDAY_BIAS;
	end

	// issue divider commands and the stepper start
	always_comb begin
		div_cmd.start = 1'b0;
		div_cmd.steps = STEPS_DAY;
		div_dvd       = {~epoch_seconds[31], epoch_seconds[30:0]};
		div_divr      = SECS_PER_DAY;
		cal_start     = 1'b0;
		case (state_q)
			S_IDLE: begin
				div_cmd.start = in_take;
			end
			S_DAY: begin
				div_cmd.start = div_stat.done;
				div_cmd.steps = STEPS_HOUR;
				div_dvd       = {secs_c, 15'd0};
				cal_start     = div_stat.done;
			end
			S_HOUR: begin
				div_divr      = SECS_PER_HOUR;
				div_cmd.start = div_stat.done;
				div_cmd.steps = STEPS_MIN;
				div_dvd       = {div_rem[11:0], 20'd0};
			end
			S_MIN: begin
				div_divr      = SECS_PER_MIN;
				div_cmd.start = div_stat.done;
				div_cmd.steps = STEPS_WDAY;
				div_dvd       = {wday_val, 15'd0};
			end
			S_WDAY: begin
				div_divr = DAYS_PER_WEEK;
			end
			S_CAL: begin
				div_divr = DAYS_PER_WEEK;
			end
			default: begin
				div_cmd.start = 1'b0;
			end
		endcase
	end

	// sequence the item and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			day_q       <= '0;
			hour_q      <= '0;
			min_q       <= '0;
			sec_q       <= '0;
			wday_q      <= '0;
			o_sec_q     <= '0;
			o_min_q     <= '0;
			o_hour_q    <= '0;
			o_wday_q    <= '0;
			o_year_q    <= '0;
			o_yday_q    <= '0;
			o_mon_q     <= '0;
			o_mday_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_DAY;
					end
				end
				S_DAY: begin
					if (div_stat.done) begin
						day_q   <= day_c;
						state_q <= S_HOUR;
					end
				end
				S_HOUR: begin
					if (div_stat.done) begin
						hour_q  <= div_quot[4:0];
						state_q <= S_MIN;
					end
				end
				S_MIN: begin
					if (div_stat.done) begin
						min_q   <= div_quot[5:0];
						sec_q   <= div_rem[5:0];
						state_q <= S_WDAY;
					end
				end
				S_WDAY: begin
					if (div_stat.done) begin
						wday_q  <= div_rem[2:0];
						state_q <= S_CAL;
					end
				end
				S_CAL: begin
					if (out_load) begin
						o_sec_q     <= sec_q;
						o_min_q     <= min_q;
						o_hour_q    <= hour_q;
						o_wday_q    <= wday_q;
						o_year_q    <= cal_year;
						o_yday_q    <= cal_yday;
						o_mon_q     <= cal_mon;
						o_mday_q    <= cal_mday;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	e2c_sdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dvd),
		.divisor  (div_divr),
		.quot     (div_quot),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	e2c_cal u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cal_start),
		.day_count (day_c),
		.busy      (cal_busy),
		.year      (cal_year),
		.yday      (cal_yday),
		.month     (cal_mon),
		.mday      (cal_mday)
	);

	assign in_stall         = state_q != S_IDLE;
	assign out_valid        = out_valid_q;
	assign second_of_minute = o_sec_q;
	assign minute_of_hour   = o_min_q;
	assign hour_of_day      = o_hour_q;
	assign day_of_week      = o_wday_q;
	assign calendar_year    = o_year_q;
	assign day_of_year      = o_yday_q;
	assign month_index      = o_mon_q;
	assign day_of_month     = o_mday_q;

endmodule
